[hw/rtl/posterize_with_luma_edge_outline_macros.svh]
// Assertion helpers for the RTL of the posterize and outline block.
// The first form is for simulation; the second leaves nothing behind for synthesis.
`ifndef POSTERIZE_WITH_LUMA_EDGE_OUTLINE_MACROS_SVH
`define POSTERIZE_WITH_LUMA_EDGE_OUTLINE_MACROS_SVH
`ifndef SYNTH
`define PLEO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PLEO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLEO_ASSERT(lbl, prop, msg)
`define PLEO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/pleo_pkg.sv]
// ----------------------------------------------------------------------------
// pleo_pkg
// Shared constants, register indexes and arithmetic helpers of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package pleo_pkg;

    localparam int PIX_W = 8;
    localparam int LUMA_W = 18;

    // Register field widths.
    localparam int IW_W = 11;
    localparam int IH_W = 13;
    localparam int LV_W = 5;
    localparam int THR_W = 18;
    localparam int RADC_W = 3;

    // Register indexes (word addresses).
    localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COLOR_LEVELS = 3'd2;
    localparam logic [2:0] REG_EDGE_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_WINDOW_RADIUS = 3'd4;
    localparam logic [2:0] REG_OUTLINE_RED = 3'd5;
    localparam logic [2:0] REG_OUTLINE_GREEN = 3'd6;
    localparam logic [2:0] REG_OUTLINE_BLUE = 3'd7;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // floor(x/510) = (x * C510) >> 23 for x up to 10455.
    localparam logic [17:0] C510 = 18'd16449;
    localparam int C510_SH = 23;
    // floor(x/L) = (x * recip(L)) >> 18 for x up to 5100.
    localparam int RECIP_SH = 18;

    function automatic logic [LUMA_W-1:0] luma(input logic [3*PIX_W-1:0] px);
        logic [LUMA_W-1:0] r;
        logic [LUMA_W-1:0] g;
        logic [LUMA_W-1:0] b;
        r = LUMA_W'(px[23:16]);
        g = LUMA_W'(px[15:8]);
        b = LUMA_W'(px[7:0]);
        return r * LUMA_W'(299) + g * LUMA_W'(587) + b * LUMA_W'(114);
    endfunction

    function automatic logic [17:0] recip(input logic [LV_W-1:0] lv);
        logic [17:0] c;
        case (lv)
            5'd2: c = 18'd131072;
            5'd3: c = 18'd87382;
            5'd4: c = 18'd65536;
            5'd5: c = 18'd52429;
            5'd6: c = 18'd43691;
            5'd7: c = 18'd37450;
            5'd8: c = 18'd32768;
            5'd9: c = 18'd29128;
            5'd10: c = 18'd26215;
            5'd11: c = 18'd23832;
            5'd12: c = 18'd21846;
            5'd13: c = 18'd20165;
            5'd14: c = 18'd18725;
            5'd15: c = 18'd17477;
            5'd16: c = 18'd16384;
            5'd17: c = 18'd15421;
            5'd18: c = 18'd14564;
            5'd19: c = 18'd13798;
            5'd20: c = 18'd13108;
            default: c = 18'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pleo_in_if.sv]
// ----------------------------------------------------------------------------
// pleo_in_if
// Pixel request channel: valid/ready with a request type and an RGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pleo_in_if
    import pleo_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
    modport sink (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

[hw/rtl/pleo_out_if.sv]
// ----------------------------------------------------------------------------
// pleo_out_if
// Result channel: valid/ready with the filtered pixel and its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface pleo_out_if
    import pleo_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             edge_flag;
    logic             frame_last;

    modport source (output valid, out_red, out_green, out_blue, edge_flag, frame_last,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, edge_flag, frame_last,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/pleo_ram.sv]
// ----------------------------------------------------------------------------
// pleo_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pleo_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 11264
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/posterize_with_luma_edge_outline.sv]
// ----------------------------------------------------------------------------
// posterize_with_luma_edge_outline
// Posterizing filter that paints luma edges of a raster RGB stream.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on pix_in as requests; req_type selects a
// pixel or a flush tick. Every pixel is kept in a ring of 2*MAX_RADIUS+1 rows.
// A result for a pixel leaves on pix_out once R*W+R further pixels or counted
// flushes are taken; flush ticks after the last pixel of a frame drain the tail.
// Each result is posterized per channel, or painted the outline color when the
// pixel lies inside the border and its largest luma difference to a window
// neighbor exceeds the threshold.
// One request is worked on at a time. An ignored flush leaves the sequencer
// idle, and any other request that yields no result only passes the decide
// step. A border pixel goes through the center, posterize and output steps;
// an interior pixel first scans its window, paced by the single line-store
// read port that visits the window one neighbor per cycle, and then drains.
// A finished result waits in an output register, so the next request is
// taken while the receiver stalls; a new result waits until it is taken.
// Reset clears all counters and loads the register defaults; the line store
// holds no defined data until written. Registers are written over APB.
// ----------------------------------------------------------------------------
`default_nettype none

`include "posterize_with_luma_edge_outline_macros.svh"

module posterize_with_luma_edge_outline
    import pleo_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_RADIUS = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    pleo_in_if.sink          pix_in,
    pleo_out_if.source       pix_out
);

    localparam int RING_ROWS = 2 * MAX_RADIUS + 1;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SLOT_W = $clog2(RING_ROWS);
    localparam int WV_W = $clog2(MAX_WIDTH + 1);
    localparam int HV_W = $clog2(MAX_HEIGHT + 1);
    localparam int RAD_W = $clog2(MAX_RADIUS + 1);
    localparam int DW = $clog2(2 * MAX_RADIUS + 1);
    localparam int CNT_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int DEPTH = RING_ROWS * (2 ** COL_W);
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECIDE = 8'b0000_0010,
        S_CENTER = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_DRAIN  = 8'b0001_0000,
        S_POST   = 8'b0010_0000,
        S_OUT    = 8'b0100_0000,
        S_SPARE  = 8'b1000_0000
    } state_t;

    typedef enum logic [3:0] {
        PH_MUL_L = 4'b0001,
        PH_MUL_Q = 4'b0010,
        PH_MUL_O = 4'b0100,
        PH_STORE = 4'b1000
    } phase_t;

    // Configuration registers.
    logic [IW_W-1:0]   image_width_reg;
    logic [IH_W-1:0]   image_height_reg;
    logic [LV_W-1:0]   color_levels_reg;
    logic [THR_W-1:0]  edge_threshold_reg;
    logic [RADC_W-1:0] window_radius_reg;
    logic [PIX_W-1:0]  outline_red_reg;
    logic [PIX_W-1:0]  outline_green_reg;
    logic [PIX_W-1:0]  outline_blue_reg;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= IW_W'(640);
            image_height_reg   <= IH_W'(480);
            color_levels_reg   <= LV_W'(6);
            edge_threshold_reg <= THR_W'(51000);
            window_radius_reg  <= RADC_W'(2);
            outline_red_reg    <= '0;
            outline_green_reg  <= '0;
            outline_blue_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:    image_width_reg <= pwdata[IW_W-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg <= pwdata[IH_W-1:0];
                REG_COLOR_LEVELS:   color_levels_reg <= pwdata[LV_W-1:0];
                REG_EDGE_THRESHOLD: edge_threshold_reg <= pwdata[THR_W-1:0];
                REG_WINDOW_RADIUS:  window_radius_reg <= pwdata[RADC_W-1:0];
                REG_OUTLINE_RED:    outline_red_reg <= pwdata[PIX_W-1:0];
                REG_OUTLINE_GREEN:  outline_green_reg <= pwdata[PIX_W-1:0];
                REG_OUTLINE_BLUE:   outline_blue_reg <= pwdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:    prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT:   prdata = 32'(image_height_reg);
            REG_COLOR_LEVELS:   prdata = 32'(color_levels_reg);
            REG_EDGE_THRESHOLD: prdata = 32'(edge_threshold_reg);
            REG_WINDOW_RADIUS:  prdata = 32'(window_radius_reg);
            REG_OUTLINE_RED:    prdata = 32'(outline_red_reg);
            REG_OUTLINE_GREEN:  prdata = 32'(outline_green_reg);
            REG_OUTLINE_BLUE:   prdata = 32'(outline_blue_reg);
            default:            prdata = '0;
        endcase
    end

    // Effective (clamped) settings.
    logic [WV_W-1:0]  w_eff;
    logic [HV_W-1:0]  h_eff;
    logic [LV_W-1:0]  lv_eff;
    logic [RAD_W-1:0] r_eff;

    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = WV_W'(1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            w_eff = WV_W'(MAX_WIDTH);
        else
            w_eff = WV_W'(image_width_reg);

        if (image_height_reg == '0)
            h_eff = HV_W'(1);
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HV_W'(MAX_HEIGHT);
        else
            h_eff = HV_W'(image_height_reg);

        if (color_levels_reg < LV_W'(2))
            lv_eff = LV_W'(2);
        else if (color_levels_reg > LV_W'(20))
            lv_eff = LV_W'(20);
        else
            lv_eff = color_levels_reg;

        if (window_radius_reg == '0)
            r_eff = RAD_W'(1);
        else if (32'(window_radius_reg) > 32'(MAX_RADIUS))
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = RAD_W'(window_radius_reg);
    end

    // The delay is registered; it is only compared in the cycle after a request is taken.
    logic [CNT_W-1:0] delay_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= '0;
        else
            delay_reg <= CNT_W'(32'(r_eff) * 32'(w_eff) + 32'(r_eff));
    end

    // Sequencer state.
    state_t            state_reg, state_next;
    phase_t            ph_reg, ph_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [SLOT_W-1:0] in_slot_reg, in_slot_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]  pending_reg, pending_next;
    logic [CNT_W-1:0]  in_flight_reg, in_flight_next;
    logic [DW-1:0]     dx_reg, dx_next;
    logic [DW-1:0]     dy_reg, dy_next;
    logic [SLOT_W-1:0] scan_slot_reg, scan_slot_next;
    logic [COL_W-1:0]  col_base_reg, col_base_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [1:0]        ch_reg, ch_next;
    logic              edge_reg, edge_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers.
    logic [3*PIX_W-1:0] px_reg;
    logic [LUMA_W-1:0]  luma_c_reg;
    logic [LUMA_W-1:0]  luma_n_reg;
    logic [LUMA_W-1:0]  maxd_reg;
    logic [31:0]        mul_reg;
    logic [PIX_W-1:0]   post_reg [3];
    logic [PIX_W-1:0]   out_red_reg, out_green_reg, out_blue_reg;
    logic               out_edge_reg, out_last_reg;

    // Line store.
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [3*PIX_W-1:0]  wdata, rdata;

    pleo_ram #(
        .WIDTH (3 * PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic in_fire, out_fire;
    assign pix_in.ready = (state_reg == S_IDLE);
    assign in_fire = pix_in.valid && pix_in.ready;
    assign out_fire = out_valid_reg && pix_out.ready;

    assign we = in_fire && (pix_in.req_type == REQ_PIXEL);
    assign waddr = AW'({in_slot_reg, in_col_reg});
    assign wdata = {pix_in.in_red, pix_in.in_green, pix_in.in_blue};

    logic [DW-1:0] r2;
    logic          is_center;
    assign r2 = DW'({r_eff, 1'b0});
    assign is_center = (dx_reg == DW'(r_eff)) && (dy_reg == DW'(r_eff));

    always_comb
    begin
        if (state_reg == S_SCAN)
            raddr = AW'({scan_slot_reg, COL_W'(col_base_reg + COL_W'(dx_reg))});
        else
            raddr = AW'({out_slot_reg, out_col_reg});
    end

    logic interior;
    assign interior = (32'(out_row_reg) >= 32'(r_eff))
                   && (32'(out_row_reg) + 32'(r_eff) < 32'(h_eff))
                   && (32'(out_col_reg) >= 32'(r_eff))
                   && (32'(out_col_reg) + 32'(r_eff) < 32'(w_eff));

    // Shared multiplier operands.
    logic [PIX_W-1:0] chan_px;
    logic [4:0]       q_val;
    logic [13:0]      mul_a;
    logic [17:0]      mul_b;

    always_comb
    begin
        case (ch_reg)
            2'd0:    chan_px = px_reg[23:16];
            2'd1:    chan_px = px_reg[15:8];
            default: chan_px = px_reg[7:0];
        endcase
        q_val = mul_reg[C510_SH+4:C510_SH];
        case (ph_reg)
            PH_MUL_L:
            begin
                mul_a = 14'(chan_px);
                mul_b = 18'(lv_eff);
            end
            PH_MUL_Q:
            begin
                mul_a = 14'({mul_reg[12:0], 1'b0}) + 14'd255;
                mul_b = C510;
            end
            PH_MUL_O:
            begin
                mul_a = 14'({q_val, 8'b0}) - 14'(q_val);
                mul_b = recip(lv_eff);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic [LUMA_W-1:0] diff;
    assign diff = (luma_c_reg >= luma_n_reg) ? luma_c_reg - luma_n_reg
                                             : luma_n_reg - luma_c_reg;

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        in_slot_next   = in_slot_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_slot_next  = out_slot_reg;
        pending_next   = pending_reg;
        in_flight_next = in_flight_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        scan_slot_next = scan_slot_reg;
        col_base_next  = col_base_reg;
        v1_next        = 1'b0;
        v2_next        = v1_reg;
        ch_next        = ch_reg;
        edge_next      = edge_reg;
        out_valid_next = out_valid_reg && !out_fire;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (pix_in.req_type == REQ_PIXEL)
                    begin
                        if (32'(in_col_reg) + 32'd1 >= 32'(w_eff))
                        begin
                            in_col_next = '0;
                            in_slot_next = (in_slot_reg == SLOT_W'(RING_ROWS - 1))
                                         ? '0 : in_slot_reg + 1'b1;
                            if (32'(in_row_reg) + 32'd1 >= 32'(h_eff))
                                in_row_next = '0;
                            else
                                in_row_next = in_row_reg + 1'b1;
                        end
                        else
                        begin
                            in_col_next = in_col_reg + 1'b1;
                        end
                        pending_next = pending_reg + 1'b1;
                        in_flight_next = in_flight_reg + 1'b1;
                        state_next = S_DECIDE;
                    end
                    else if (in_col_reg == '0 && in_row_reg == '0 && pending_reg != '0)
                    begin
                        // A flush only counts once a whole frame is in.
                        in_flight_next = in_flight_reg + 1'b1;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (in_flight_reg > delay_reg && pending_reg != '0)
                    state_next = S_CENTER;
                else
                    state_next = S_IDLE;
            end
            S_CENTER:
            begin
                // The center pixel is on the read data now.
                dx_next = '0;
                dy_next = '0;
                col_base_next = out_col_reg - COL_W'(r_eff);
                scan_slot_next = (out_slot_reg >= SLOT_W'(r_eff))
                               ? out_slot_reg - SLOT_W'(r_eff)
                               : SLOT_W'(32'(out_slot_reg) + RING_ROWS - 32'(r_eff));
                edge_next = 1'b0;
                ch_next = '0;
                ph_next = PH_MUL_L;
                state_next = interior ? S_SCAN : S_POST;
            end
            S_SCAN:
            begin
                v1_next = !is_center;
                if (dx_reg == r2)
                begin
                    dx_next = '0;
                    dy_next = dy_reg + 1'b1;
                    scan_slot_next = (scan_slot_reg == SLOT_W'(RING_ROWS - 1))
                                   ? '0 : scan_slot_reg + 1'b1;
                    if (dy_reg == r2)
                        state_next = S_DRAIN;
                end
                else
                begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    edge_next = maxd_reg > edge_threshold_reg;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (edge_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    case (ph_reg)
                        PH_MUL_L: ph_next = PH_MUL_Q;
                        PH_MUL_Q: ph_next = PH_MUL_O;
                        PH_MUL_O: ph_next = PH_STORE;
                        default:
                        begin
                            ph_next = PH_MUL_L;
                            ch_next = ch_reg + 1'b1;
                            if (ch_reg == 2'd2)
                                state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_next = 1'b1;
                    if (32'(out_col_reg) + 32'd1 >= 32'(w_eff))
                    begin
                        out_col_next = '0;
                        out_slot_next = (out_slot_reg == SLOT_W'(RING_ROWS - 1))
                                      ? '0 : out_slot_reg + 1'b1;
                        if (32'(out_row_reg) + 32'd1 >= 32'(h_eff))
                            out_row_next = '0;
                        else
                            out_row_next = out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                    pending_next = pending_reg - 1'b1;
                    in_flight_next = (pending_reg == CNT_W'(1)) ? '0 : in_flight_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= PH_MUL_L;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            pending_reg   <= '0;
            in_flight_reg <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            scan_slot_reg <= '0;
            col_base_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            ch_reg        <= '0;
            edge_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_slot_reg  <= out_slot_next;
            pending_reg   <= pending_next;
            in_flight_reg <= in_flight_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            scan_slot_reg <= scan_slot_next;
            col_base_reg  <= col_base_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            ch_reg        <= ch_next;
            edge_reg      <= edge_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: window luma pipeline, shared multiplier and output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CENTER)
        begin
            px_reg <= rdata;
            luma_c_reg <= luma(rdata);
            maxd_reg <= '0;
        end
        if (v1_reg)
        begin
            luma_n_reg <= luma(rdata);
        end
        if (v2_reg && diff > maxd_reg)
        begin
            maxd_reg <= diff;
        end
        if (state_reg == S_POST)
        begin
            mul_reg <= 32'(mul_a) * 32'(mul_b);
            if (ph_reg == PH_STORE)
                post_reg[ch_reg] <= mul_reg[RECIP_SH+7:RECIP_SH];
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_fire))
        begin
            out_red_reg   <= edge_reg ? outline_red_reg : post_reg[0];
            out_green_reg <= edge_reg ? outline_green_reg : post_reg[1];
            out_blue_reg  <= edge_reg ? outline_blue_reg : post_reg[2];
            out_edge_reg  <= edge_reg;
            out_last_reg  <= (32'(out_col_reg) + 32'd1 == 32'(w_eff))
                          && (32'(out_row_reg) + 32'd1 == 32'(h_eff));
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_red    = out_red_reg;
    assign pix_out.out_green  = out_green_reg;
    assign pix_out.out_blue   = out_blue_reg;
    assign pix_out.edge_flag  = out_edge_reg;
    assign pix_out.frame_last = out_last_reg;

    `PLEO_ASSERT(a_pending_le_flight, pending_reg <= in_flight_reg, "pending exceeds in-flight count")
    `PLEO_ASSERT(a_scan_in_window, state_reg != S_SCAN || (dx_reg <= r2 && dy_reg <= r2), "window scan out of range")
    `PLEO_ASSERT_NEXT(a_result_from_out, !out_valid_reg && state_reg != S_OUT, !out_valid_reg, "result appeared outside the output step")

endmodule

`default_nettype wire

[tb/sv/posterize_with_luma_edge_outline_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posterize_with_luma_edge_outline_tb
// Streams raster frames and flush ticks through the filter under several
// register settings, with random idling on both channels. Every result is
// compared field by field against a bench model or a directed expected value.
// ----------------------------------------------------------------------------
`default_nettype none

module posterize_with_luma_edge_outline_tb;
    import pleo_pkg::*;

    localparam int RING = 11;
    localparam int MAXW = 1024;
    localparam int MAXH = 4096;
    localparam int MAXR = 5;
    localparam int SETTLE = 300;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       edge_flag;
        logic       frame_last;
    } pix_result_t;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_FLUSH, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        logic [23:0] rgb;
        bit          typed;
        pix_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    pleo_in_if  in_ch ();
    pleo_out_if out_ch ();

    posterize_with_luma_edge_outline DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (in_ch),
        .pix_out (out_ch)
    );

    always #2 clk = ~clk;

    // Shadow registers and filter state of the model.
    int unsigned cfg_width, cfg_height, cfg_levels, cfg_thresh, cfg_radius;
    logic [7:0]  cfg_out_r, cfg_out_g, cfg_out_b;
    logic [23:0] row_ring [RING*MAXW];
    int unsigned in_col, in_row, in_slot, out_col, out_row, out_slot;
    int unsigned pending_pix, in_flight;

    pix_result_t expected_pixels[$];
    int          errors = 0;
    int unsigned sent_count = 0;
    int unsigned cyc = 0;

    always @(posedge clk) cyc <= cyc + 1;

    // A long window in the middle of the run has no idling on either side.
    function automatic bit calm();
        return cyc >= 20000 && cyc < 60000;
    endfunction

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int luma_of(logic [23:0] px);
        return 299 * px[23:16] + 587 * px[15:8] + 114 * px[7:0];
    endfunction

    function automatic logic [7:0] posterize(int unsigned p, int unsigned lv);
        int unsigned q;
        q = (2 * p * lv + 255) / 510;
        return 8'((q * 255) / lv);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic step_raster(ref int unsigned col, ref int unsigned row, ref int unsigned slot,
                               input int unsigned w, input int unsigned h);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            slot = (slot + 1) % RING;
            if (row >= h)
                row = 0;
        end
    endtask

    task automatic filter_model(input logic rq, input logic [23:0] px_in,
                                output bit has, output pix_result_t res);
        int unsigned w, h, lv, r, delay, c, rw, s;
        logic [23:0] px;
        int          lc, maxd, d;
        bit          is_edge;
        w = clampu(cfg_width, 1, MAXW);
        h = clampu(cfg_height, 1, MAXH);
        lv = clampu(cfg_levels, 2, 20);
        r = clampu(cfg_radius, 1, MAXR);
        delay = r * w + r;
        has = 1'b0;
        res = '0;
        is_edge = 1'b0;
        if (rq == REQ_PIXEL) begin
            row_ring[(in_slot % RING) * MAXW + (in_col % MAXW)] = px_in;
            step_raster(in_col, in_row, in_slot, w, h);
            pending_pix++;
            in_flight++;
        end
        else begin
            // A flush only counts once a frame is complete and pixels remain.
            if (in_col != 0 || in_row != 0 || pending_pix == 0)
                return;
            in_flight++;
        end
        if (in_flight <= delay || pending_pix == 0)
            return;
        c = out_col;
        rw = out_row;
        px = row_ring[(out_slot % RING) * MAXW + (c % MAXW)];
        if (rw >= r && rw + r < h && c >= r && c + r < w) begin
            lc = luma_of(px);
            maxd = 0;
            for (int unsigned dy = 0; dy <= 2 * r; dy++) begin
                s = (out_slot + RING + dy - r) % RING;
                for (int unsigned dx = 0; dx <= 2 * r; dx++) begin
                    if (dx == r && dy == r)
                        continue;
                    d = lc - luma_of(row_ring[s * MAXW + ((c + dx - r) % MAXW)]);
                    if (d < 0)
                        d = -d;
                    if (d > maxd)
                        maxd = d;
                end
            end
            is_edge = maxd > cfg_thresh;
        end
        if (is_edge) begin
            res.red = cfg_out_r;
            res.green = cfg_out_g;
            res.blue = cfg_out_b;
        end
        else begin
            res.red = posterize(px[23:16], lv);
            res.green = posterize(px[15:8], lv);
            res.blue = posterize(px[7:0], lv);
        end
        res.edge_flag = is_edge;
        res.frame_last = (c == w - 1 && rw == h - 1);
        has = 1'b1;
        step_raster(out_col, out_row, out_slot, w, h);
        pending_pix--;
        in_flight--;
        if (pending_pix == 0)
            in_flight = 0;
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input logic rq, input logic [23:0] rgb,
                                input bit typed, input pix_result_t want);
        bit          has;
        pix_result_t res;
        while (!calm() && $urandom_range(99) < 9) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= rq;
        in_ch.in_red <= rgb[23:16];
        in_ch.in_green <= rgb[15:8];
        in_ch.in_blue <= rgb[7:0];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        filter_model(rq, rgb, has, res);
        sent_count++;
        if (has)
            expected_pixels.push_back(typed ? want : res);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:    cfg_width = value[10:0];
            REG_IMAGE_HEIGHT:   cfg_height = value[12:0];
            REG_COLOR_LEVELS:   cfg_levels = value[4:0];
            REG_EDGE_THRESHOLD: cfg_thresh = value[17:0];
            REG_WINDOW_RADIUS:  cfg_radius = value[2:0];
            REG_OUTLINE_RED:    cfg_out_r = value[7:0];
            REG_OUTLINE_GREEN:  cfg_out_g = value[7:0];
            REG_OUTLINE_BLUE:   cfg_out_b = value[7:0];
            default: ;
        endcase
    endtask

    task automatic drain_tail();
        while (pending_pix != 0)
            send_request(REQ_FLUSH, 24'h0, 1'b0, '0);
    endtask

    task automatic run_phase(input logic [31:0] w, input logic [31:0] h, input logic [31:0] lv,
                             input logic [31:0] thr, input logic [31:0] rad,
                             input int frames);
        int unsigned ew, eh, split;
        logic [23:0] tone_a, tone_b, px;
        int          mode;
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_COLOR_LEVELS, lv);
        write_reg(REG_EDGE_THRESHOLD, thr);
        write_reg(REG_WINDOW_RADIUS, rad);
        write_reg(REG_OUTLINE_RED, $urandom_range(255));
        write_reg(REG_OUTLINE_GREEN, $urandom_range(255));
        write_reg(REG_OUTLINE_BLUE, $urandom_range(255));
        ew = clampu(cfg_width, 1, MAXW);
        eh = clampu(cfg_height, 1, MAXH);
        for (int f = 0; f < frames; f++) begin
            mode = $urandom_range(2);
            tone_a = 24'($urandom);
            tone_b = 24'($urandom);
            split = $urandom_range(ew);
            for (int unsigned k = 0; k < ew * eh; k++) begin
                // Stray flushes inside a frame must be ignored.
                if ($urandom_range(99) < 4)
                    send_request(REQ_FLUSH, 24'($urandom), 1'b0, '0);
                if (mode == 0)
                    px = 24'($urandom);
                else if (mode == 1)
                    px = (k % ew) < split ? tone_a : tone_b;
                else
                    px = ($urandom_range(7) == 0) ? tone_b : tone_a;
                send_request(REQ_PIXEL, px, 1'b0, '0);
            end
            // Sometimes the next frame pushes out the tail instead of flushes.
            if (f == frames - 1 || $urandom_range(1) == 0) begin
                drain_tail();
                repeat ($urandom_range(2))
                    send_request(REQ_FLUSH, 24'h0, 1'b0, '0);
            end
        end
    endtask

    // The sink samples at each rising edge and redraws ready for the next one.
    always @(posedge clk) begin
        pix_result_t want;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result with no pending expectation", 1, 0);
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (out_ch.out_red !== want.red)
                        report_mismatch("out_red", out_ch.out_red, want.red);
                    if (out_ch.out_green !== want.green)
                        report_mismatch("out_green", out_ch.out_green, want.green);
                    if (out_ch.out_blue !== want.blue)
                        report_mismatch("out_blue", out_ch.out_blue, want.blue);
                    if (out_ch.edge_flag !== want.edge_flag)
                        report_mismatch("edge_flag", out_ch.edge_flag, want.edge_flag);
                    if (out_ch.frame_last !== want.frame_last)
                        report_mismatch("frame_last", out_ch.frame_last, want.frame_last);
                end
            end
            out_ch.ready <= calm() || $urandom_range(99) >= 9;
        end
    end

    stim_row_t directed[$];

    task automatic add_row(input row_kind_t kind, input logic [2:0] idx, input logic [31:0] value,
                           input logic [23:0] rgb, input bit typed, input pix_result_t want);
        stim_row_t row;
        row.kind = kind;
        row.reg_idx = idx;
        row.value = value;
        row.rgb = rgb;
        row.typed = typed;
        row.want = want;
        directed.push_back(row);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_PIXEL;
        in_ch.in_red = '0;
        in_ch.in_green = '0;
        in_ch.in_blue = '0;
        out_ch.ready = 1'b0;
        cfg_width = 640;
        cfg_height = 480;
        cfg_levels = 6;
        cfg_thresh = 51000;
        cfg_radius = 2;
        cfg_out_r = '0;
        cfg_out_g = '0;
        cfg_out_b = '0;
        in_col = 0; in_row = 0; in_slot = 0;
        out_col = 0; out_row = 0; out_slot = 0;
        pending_pix = 0;
        in_flight = 0;
        foreach (row_ring[i])
            row_ring[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-pixel frames at the coarsest posterization, then a 3x3 frame
        // whose center is the only interior pixel.
        add_row(ROW_CFG, REG_IMAGE_WIDTH, 1, 0, 0, '0);
        add_row(ROW_CFG, REG_IMAGE_HEIGHT, 1, 0, 0, '0);
        add_row(ROW_CFG, REG_WINDOW_RADIUS, 1, 0, 0, '0);
        add_row(ROW_CFG, REG_COLOR_LEVELS, 0, 0, 0, '0);
        add_row(ROW_CFG, REG_EDGE_THRESHOLD, 0, 0, 0, '0);
        add_row(ROW_FLUSH, 0, 0, 24'h0, 0, '0);
        add_row(ROW_PIXEL, 0, 0, 24'hFF00FF, 0, '0);
        add_row(ROW_FLUSH, 0, 0, 24'h0, 0, '0);
        add_row(ROW_FLUSH, 0, 0, 24'h0, 1, '{8'd255, 8'd0, 8'd255, 1'b0, 1'b1});
        add_row(ROW_FLUSH, 0, 0, 24'h0, 0, '0);
        add_row(ROW_PIXEL, 0, 0, 24'h000000, 0, '0);
        add_row(ROW_FLUSH, 0, 0, 24'h0, 0, '0);
        add_row(ROW_FLUSH, 0, 0, 24'h0, 1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1});
        add_row(ROW_CFG, REG_IMAGE_WIDTH, 3, 0, 0, '0);
        add_row(ROW_CFG, REG_IMAGE_HEIGHT, 3, 0, 0, '0);
        add_row(ROW_CFG, REG_OUTLINE_RED, 255, 0, 0, '0);
        for (int i = 0; i < 9; i++)
            add_row(ROW_PIXEL, 0, 0, i == 4 ? 24'hC80A1E : 24'h646464, 0, '0);
        repeat (4)
            add_row(ROW_FLUSH, 0, 0, 24'h0, 0, '0);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed[i].reg_idx, directed[i].value);
            end
            else
                send_request(directed[i].kind == ROW_FLUSH ? REQ_FLUSH : REQ_PIXEL,
                             directed[i].rgb, directed[i].typed, directed[i].want);
        end

        // Out-of-range settings: zero width, height and radius, top levels and
        // threshold, levels below two, radius above the largest window.
        run_phase(0, 0, 31, 262143, 0, 1);
        run_phase(14, 12, 1, 255000, 7, 1);
        run_phase(12, 12, 20, 0, 5, 1);
        while (sent_count < 1050) begin
            run_phase($urandom_range(15) == 0 ? 0 : $urandom_range(1, 14),
                      $urandom_range(1, 14),
                      $urandom_range(31),
                      $urandom_range(3) == 0 ? 255000 : $urandom_range(60000),
                      $urandom_range(7),
                      $urandom_range(1, 3));
        end

        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
